/* hw/rtl/sdsh_pkg.sv */
// ----------------------------------------------------------------------------
// sdsh_pkg
// Shared types and constants of the SD card SPI-mode host sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sdsh_pkg;

  localparam int SECTOR_BYTES  = 512;
  localparam int RELEASE_BYTES = 10;
  localparam int WAKE_BYTES    = 10;
  localparam int FRAME_BYTES   = 8;
  localparam int BCNT_W        = 10;
  localparam int LBA_W         = 23;
  localparam int TMO_W         = 16;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] BYTE_IDLE   = 8'hff;
  localparam logic [7:0] BYTE_CMD    = 8'h40;
  localparam logic [7:0] BYTE_CRC    = 8'h95;
  localparam logic [7:0] BYTE_TOKEN  = 8'hfe;
  localparam logic [7:0] RESP_MASK   = 8'h1f;
  localparam logic [7:0] RESP_ACCEPT = 8'h05;
  localparam logic [7:0] REPLY_IDLE  = 8'h01;
  localparam logic [7:0] REPLY_READY = 8'h00;
  localparam logic [TMO_W-1:0] TMO_MAX = 16'hffff;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_XCHG  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OPER_NONE  = 2'd0,
    OPER_INIT  = 2'd1,
    OPER_READ  = 2'd2,
    OPER_WRITE = 2'd3
  } oper_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_IDLE  = 3'd1,
    ST_INIT_TMO = 3'd2,
    ST_TOKEN_TMO = 3'd3,
    ST_WR_REJ   = 3'd4,
    ST_BUSY_TMO = 3'd5
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_WAKE, PH_CMD0, PH_CMD1, PH_CMD16, PH_CMD17, PH_CMD24,
    PH_GET_IDLE, PH_OPCOND, PH_TOKEN, PH_RDATA, PH_RCRC, PH_WREPLY,
    PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP, PH_BUSY, PH_RELEASE
  } phase_t;

  typedef struct packed {
    kind_t            kind;
    logic [LBA_W-1:0] lba;
    logic [7:0]       miso_byte;
    logic [7:0]       write_byte;
  } entry_t;

  typedef struct packed {
    logic [7:0] mosi_byte;
    logic       mosi_valid;
    logic       chip_select_active;
    logic       fast_clock;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       write_take;
    logic       done_res;
    logic [2:0] status;
    logic [7:0] card_response;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/sdsh_if.sv */
// ----------------------------------------------------------------------------
// sdsh_if
// Channel interfaces: input items, result items and the configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface sdsh_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [22:0] lba;
  logic [7:0]  miso_byte;
  logic [7:0]  write_byte;
  modport source (output valid, opcode, lba, miso_byte, write_byte, input ready);
  modport sink   (input valid, opcode, lba, miso_byte, write_byte, output ready);
endinterface

interface sdsh_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mosi_byte;
  logic       mosi_valid;
  logic       chip_select_active;
  logic       fast_clock;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       write_take;
  logic       done_res;
  logic [2:0] status;
  logic [7:0] card_response;
  modport source (output valid, mosi_byte, mosi_valid, chip_select_active, fast_clock,
                  read_byte, read_valid, write_take, done_res, status, card_response,
                  input ready);
  modport sink   (input valid, mosi_byte, mosi_valid, chip_select_active, fast_clock,
                  read_byte, read_valid, write_take, done_res, status, card_response,
                  output ready);
endinterface

interface sdsh_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sd_spi_host_sequencer.sv */
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// SD card SPI-mode host sequencer: turns init, read and write requests and
// completed SPI beats into the next MOSI byte, chip select and sector data.
//
//   Channel  Direction  Beat carries
//   in_ch    sink       opcode, lba, miso_byte, write_byte
//   out_ch   source     mosi byte and flags, read data, done and status
//   cfg_ch   sink       timeout_limit (16 bits)
//
// One item per cycle is taken and one result per cycle is given, sustained
// while out_ch.ready holds. An item is written into the two-entry queue at
// the accepting edge; its result enters the output register when it is popped.
// A stalled output fills the queue, after which in_ch.ready falls.
// Synchronous reset returns the sequencer to idle with slow clock and chip
// select inactive; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_spi_host_sequencer (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sdsh_in_if.sink    in_ch,
  sdsh_cfg_if.sink   cfg_ch,
  sdsh_out_if.source out_ch
);
  import sdsh_pkg::*;

  entry_t push_entry;
  entry_t pop_entry;
  logic   push;
  logic   push_ready;
  logic   pop;
  logic   pop_valid;

  sdsh_front u_front (
    .in_ch   (in_ch),
    .q_ready (push_ready),
    .q_entry (push_entry),
    .q_push  (push)
  );

  sdsh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid)
  );

  sdsh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_entry (pop_entry),
    .q_valid (pop_valid),
    .q_pop   (pop),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

/* hw/rtl/sdsh_front.sv */
// ----------------------------------------------------------------------------
// sdsh_front
// Input side: takes items from the host channel and classifies them.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsh_front (
  sdsh_in_if.sink          in_ch,
  input  wire logic        q_ready,
  output sdsh_pkg::entry_t q_entry,
  output logic             q_push
);
  import sdsh_pkg::*;

  kind_t kind;

  always_comb begin
    unique case (in_ch.opcode)
      KIND_INIT:  kind = KIND_INIT;
      KIND_READ:  kind = KIND_READ;
      KIND_WRITE: kind = KIND_WRITE;
      default:    kind = KIND_XCHG;
    endcase
  end

  assign in_ch.ready        = q_ready;
  assign q_push             = in_ch.valid & q_ready;
  assign q_entry.kind       = kind;
  assign q_entry.lba        = in_ch.lba;
  assign q_entry.miso_byte  = in_ch.miso_byte;
  assign q_entry.write_byte = in_ch.write_byte;

endmodule

`default_nettype wire

/* hw/rtl/sdsh_queue.sv */
// ----------------------------------------------------------------------------
// sdsh_queue
// Two-entry queue between the classifying front and the sequencing back.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsh_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sdsh_pkg::entry_t  push_entry,
  output logic                   push_ready,
  input  wire logic              pop,
  output sdsh_pkg::entry_t       pop_entry,
  output logic                   pop_valid
);
  import sdsh_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W:0]     count_r;
  logic [PTR_W:0]     count_nxt;

  assign push_ready = (count_r != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sdsh_back.sv */
// ----------------------------------------------------------------------------
// sdsh_back
// Command sequencer: walks the card protocol one completed beat at a time
// and holds each result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sdsh_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sdsh_pkg::entry_t q_entry,
  input  wire logic             q_valid,
  output logic                  q_pop,
  sdsh_cfg_if.sink              cfg_ch,
  sdsh_out_if.source            out_ch
);
  import sdsh_pkg::*;

  localparam logic [BCNT_W-1:0] WAKE_LAST    = BCNT_W'(WAKE_BYTES - 1);
  localparam logic [BCNT_W-1:0] FRAME_LAST   = BCNT_W'(FRAME_BYTES - 1);
  localparam logic [BCNT_W-1:0] SECTOR_LAST  = BCNT_W'(SECTOR_BYTES - 1);
  localparam logic [BCNT_W-1:0] RELEASE_LAST = BCNT_W'(RELEASE_BYTES - 1);

  localparam logic [7:0] SD_CMD0  = 8'd0;
  localparam logic [7:0] SD_CMD1  = 8'd1;
  localparam logic [7:0] SD_CMD16 = 8'd16;
  localparam logic [7:0] SD_CMD17 = 8'd17;
  localparam logic [7:0] SD_CMD24 = 8'd24;

  phase_t             phase_r, phase_nxt;
  logic [BCNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TMO_W-1:0]   poll_r, poll_nxt;
  logic [LBA_W-1:0]   lba_r, lba_nxt;
  oper_t              oper_r, oper_nxt;
  logic               fast_r, fast_nxt;
  logic               cs_r, cs_nxt;
  status_t            rel_st_r, rel_st_nxt;
  logic [7:0]         rel_resp_r, rel_resp_nxt;
  logic [TMO_W-1:0]   limit_r;
  logic               out_valid_r;
  result_t            res_r, res;
  logic               fire;
  logic [TMO_W-1:0]   poll_inc;
  logic [TMO_W-1:0]   limit_eff;
  logic               expired;
  logic [BCNT_W-1:0]  cnt_inc;
  logic [7:0]         miso;

  function automatic logic [7:0] frame_byte(phase_t ph, logic [2:0] idx,
                                            logic [LBA_W-1:0] lba);
    logic [7:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  b;
    cmd = SD_CMD0;
    arg = 32'd0;
    unique case (ph)
      PH_CMD1:  cmd = SD_CMD1;
      PH_CMD16: begin
        cmd = SD_CMD16;
        arg = 32'(SECTOR_BYTES);
      end
      PH_CMD17: begin
        cmd = SD_CMD17;
        arg = {lba, 9'd0};
      end
      PH_CMD24: begin
        cmd = SD_CMD24;
        arg = {lba, 9'd0};
      end
      default:  cmd = SD_CMD0;
    endcase
    case (idx)
      3'd1:    b = cmd | BYTE_CMD;
      3'd2:    b = arg[31:24];
      3'd3:    b = arg[23:16];
      3'd4:    b = arg[15:8];
      3'd5:    b = arg[7:0];
      3'd6:    b = BYTE_CRC;
      default: b = BYTE_IDLE;
    endcase
    return b;
  endfunction

  assign fire          = q_valid && (!out_valid_r || out_ch.ready);
  assign q_pop         = fire;
  assign cfg_ch.ready  = 1'b1;
  assign miso          = q_entry.miso_byte;
  assign cnt_inc       = cnt_r + 1'b1;
  assign poll_inc      = (poll_r != TMO_MAX) ? poll_r + 1'b1 : poll_r;
  assign limit_eff     = (limit_r != '0) ? limit_r : TMO_W'(1);
  assign expired       = (poll_inc >= limit_eff);

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    poll_nxt     = poll_r;
    lba_nxt      = lba_r;
    oper_nxt     = oper_r;
    fast_nxt     = fast_r;
    cs_nxt       = cs_r;
    rel_st_nxt   = rel_st_r;
    rel_resp_nxt = rel_resp_r;
    res          = '0;

    if (q_entry.kind == KIND_XCHG) begin
      unique case (phase_r)
        PH_IDLE: begin
        end
        PH_WAKE: begin
          res.mosi_valid = 1'b1;
          if (cnt_r < WAKE_LAST) begin
            cnt_nxt       = cnt_inc;
            res.mosi_byte = BYTE_IDLE;
          end else begin
            phase_nxt     = PH_CMD0;
            cnt_nxt       = '0;
            cs_nxt        = 1'b1;
            res.mosi_byte = BYTE_IDLE;
          end
        end
        PH_CMD0, PH_CMD1, PH_CMD16, PH_CMD17, PH_CMD24: begin
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (cnt_r < FRAME_LAST) begin
            cnt_nxt       = cnt_inc;
            res.mosi_byte = frame_byte(phase_r, cnt_inc[2:0], lba_r);
          end else if (phase_r == PH_CMD0) begin
            phase_nxt = PH_GET_IDLE;
            poll_nxt  = '0;
          end else if (phase_r == PH_CMD1) begin
            phase_nxt = PH_OPCOND;
          end else if (phase_r == PH_CMD16) begin
            rel_st_nxt   = ST_OK;
            rel_resp_nxt = '0;
            phase_nxt    = PH_RELEASE;
            cnt_nxt      = '0;
          end else if (phase_r == PH_CMD17) begin
            phase_nxt = PH_TOKEN;
            poll_nxt  = '0;
          end else begin
            phase_nxt = PH_WREPLY;
            poll_nxt  = '0;
          end
        end
        PH_GET_IDLE: begin
          poll_nxt = poll_inc;
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (miso != BYTE_IDLE) begin
            if (miso == REPLY_IDLE) begin
              phase_nxt = PH_OPCOND;
              poll_nxt  = '0;
            end else begin
              rel_st_nxt   = ST_NO_IDLE;
              rel_resp_nxt = '0;
              phase_nxt    = PH_RELEASE;
              cnt_nxt      = '0;
            end
          end else if (expired) begin
            rel_st_nxt   = ST_NO_IDLE;
            rel_resp_nxt = '0;
            phase_nxt    = PH_RELEASE;
            cnt_nxt      = '0;
          end
        end
        PH_OPCOND: begin
          poll_nxt = poll_inc;
          if (miso == REPLY_READY) begin
            phase_nxt      = PH_CMD16;
            cnt_nxt        = '0;
            cs_nxt         = 1'b1;
            res.mosi_valid = 1'b1;
            res.mosi_byte  = BYTE_IDLE;
          end else if (expired) begin
            res.done_res = 1'b1;
            res.status   = ST_INIT_TMO;
            phase_nxt    = PH_IDLE;
          end else begin
            phase_nxt      = PH_CMD1;
            cnt_nxt        = '0;
            cs_nxt         = 1'b1;
            res.mosi_valid = 1'b1;
            res.mosi_byte  = BYTE_IDLE;
          end
        end
        PH_TOKEN: begin
          poll_nxt = poll_inc;
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (miso == BYTE_TOKEN) begin
            phase_nxt = PH_RDATA;
            cnt_nxt   = '0;
          end else if (expired) begin
            rel_st_nxt   = ST_TOKEN_TMO;
            rel_resp_nxt = '0;
            phase_nxt    = PH_RELEASE;
            cnt_nxt      = '0;
          end
        end
        PH_RDATA: begin
          res.read_byte  = miso;
          res.read_valid = 1'b1;
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (cnt_r < SECTOR_LAST) begin
            cnt_nxt = cnt_inc;
          end else begin
            phase_nxt = PH_RCRC;
            cnt_nxt   = '0;
          end
        end
        PH_RCRC: begin
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (cnt_r == '0) begin
            cnt_nxt = BCNT_W'(1);
          end else begin
            rel_st_nxt   = ST_OK;
            rel_resp_nxt = '0;
            phase_nxt    = PH_RELEASE;
            cnt_nxt      = '0;
          end
        end
        PH_WREPLY: begin
          poll_nxt = poll_inc;
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (miso != BYTE_IDLE || expired) begin
            phase_nxt     = PH_WTOKEN;
            res.mosi_byte = BYTE_TOKEN;
          end
        end
        PH_WTOKEN: begin
          phase_nxt      = PH_WDATA;
          cnt_nxt        = '0;
          res.mosi_valid = 1'b1;
          res.mosi_byte  = q_entry.write_byte;
          res.write_take = 1'b1;
        end
        PH_WDATA: begin
          res.mosi_valid = 1'b1;
          if (cnt_r < SECTOR_LAST) begin
            cnt_nxt        = cnt_inc;
            res.mosi_byte  = q_entry.write_byte;
            res.write_take = 1'b1;
          end else begin
            phase_nxt     = PH_WCRC;
            cnt_nxt       = '0;
            res.mosi_byte = BYTE_IDLE;
          end
        end
        PH_WCRC: begin
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (cnt_r == '0) begin
            cnt_nxt = BCNT_W'(1);
          end else begin
            phase_nxt = PH_WRESP;
          end
        end
        PH_WRESP: begin
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if ((miso & RESP_MASK) != RESP_ACCEPT) begin
            rel_st_nxt   = ST_WR_REJ;
            rel_resp_nxt = miso;
            phase_nxt    = PH_RELEASE;
            cnt_nxt      = '0;
          end else begin
            phase_nxt = PH_BUSY;
            poll_nxt  = '0;
          end
        end
        PH_BUSY: begin
          poll_nxt = poll_inc;
          res.mosi_valid = 1'b1;
          res.mosi_byte  = BYTE_IDLE;
          if (miso != REPLY_READY) begin
            rel_st_nxt   = ST_OK;
            rel_resp_nxt = '0;
            phase_nxt    = PH_RELEASE;
            cnt_nxt      = '0;
          end else if (expired) begin
            rel_st_nxt   = ST_BUSY_TMO;
            rel_resp_nxt = '0;
            phase_nxt    = PH_RELEASE;
            cnt_nxt      = '0;
          end
        end
        PH_RELEASE: begin
          if (cnt_r < RELEASE_LAST) begin
            cnt_nxt        = cnt_inc;
            res.mosi_valid = 1'b1;
            res.mosi_byte  = BYTE_IDLE;
          end else begin
            cs_nxt = 1'b0;
            if (oper_r == OPER_INIT && rel_st_r == ST_OK) begin
              fast_nxt = 1'b1;
            end
            res.done_res      = 1'b1;
            res.status        = rel_st_r;
            res.card_response = rel_resp_r;
            phase_nxt         = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end else if (phase_r == PH_IDLE) begin
      rel_st_nxt     = ST_OK;
      rel_resp_nxt   = '0;
      cnt_nxt        = '0;
      poll_nxt       = '0;
      res.mosi_valid = 1'b1;
      res.mosi_byte  = BYTE_IDLE;
      if (q_entry.kind == KIND_INIT) begin
        oper_nxt  = OPER_INIT;
        fast_nxt  = 1'b0;
        cs_nxt    = 1'b0;
        phase_nxt = PH_WAKE;
      end else begin
        oper_nxt  = (q_entry.kind == KIND_READ) ? OPER_READ : OPER_WRITE;
        lba_nxt   = q_entry.lba;
        cs_nxt    = 1'b1;
        phase_nxt = (q_entry.kind == KIND_READ) ? PH_CMD17 : PH_CMD24;
      end
    end

    res.chip_select_active = cs_nxt;
    res.fast_clock         = fast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cnt_r       <= '0;
      poll_r      <= '0;
      lba_r       <= '0;
      oper_r      <= OPER_NONE;
      fast_r      <= 1'b0;
      cs_r        <= 1'b0;
      rel_st_r    <= ST_OK;
      rel_resp_r  <= '0;
      limit_r     <= TMO_MAX;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.data;
      end
      if (fire) begin
        phase_r    <= phase_nxt;
        cnt_r      <= cnt_nxt;
        poll_r     <= poll_nxt;
        lba_r      <= lba_nxt;
        oper_r     <= oper_nxt;
        fast_r     <= fast_nxt;
        cs_r       <= cs_nxt;
        rel_st_r   <= rel_st_nxt;
        rel_resp_r <= rel_resp_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.mosi_byte          = res_r.mosi_byte;
  assign out_ch.mosi_valid         = res_r.mosi_valid;
  assign out_ch.chip_select_active = res_r.chip_select_active;
  assign out_ch.fast_clock         = res_r.fast_clock;
  assign out_ch.read_byte          = res_r.read_byte;
  assign out_ch.read_valid         = res_r.read_valid;
  assign out_ch.write_take         = res_r.write_take;
  assign out_ch.done_res           = res_r.done_res;
  assign out_ch.status             = res_r.status;
  assign out_ch.card_response      = res_r.card_response;

endmodule

`default_nettype wire
